FILE: sv/tsr_pkg.sv
package tsr_pkg;

    localparam int unsigned TIME_SCALE = 1000000;
    localparam int TS_W    = $clog2(TIME_SCALE + 1);
    localparam int RATE_W  = 31;
    localparam int MD_W    = RATE_W + TS_W;          // multiplier / divisor width
    localparam int M_LO_W  = (MD_W + 1) / 2;
    localparam int M_HI_W  = MD_W - M_LO_W;
    localparam int X_W     = 64;
    localparam int XH_W    = X_W / 2;
    localparam int PP_W    = XH_W + M_LO_W;
    localparam int PROD_W  = X_W + MD_W;
    localparam int DC_W    = $clog2(PROD_W);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int ADDR_W  = 5;

    localparam logic [2:0] MODE_S2T     = 3'd0;
    localparam logic [2:0] MODE_T2S     = 3'd1;
    localparam logic [2:0] MODE_RESCALE = 3'd2;
    localparam logic [2:0] MODE_T2F     = 3'd3;
    localparam logic [2:0] MODE_F2T     = 3'd4;

    localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [2:0] REG_SCALE_FROM  = 3'd1;
    localparam logic [2:0] REG_SCALE_TO    = 3'd2;
    localparam logic [2:0] REG_FRAME_NUM   = 3'd3;
    localparam logic [2:0] REG_FRAME_DEN   = 3'd4;

    typedef struct packed {
        logic [2:0]     mode;
        logic           ok;
        logic           neg;
        logic [X_W-1:0] mag;
    } t_req;

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate;
        logic [RATE_W-1:0] scale_from;
        logic [RATE_W-1:0] scale_to;
        logic [RATE_W-1:0] frame_num;
        logic [RATE_W-1:0] frame_den;
    } t_cfg;

endpackage

FILE: sv/tsr_front.sv
module tsr_front import tsr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2:0]     i_mode,
    input  logic [X_W-1:0] i_value_in,
    input  logic           i_pop,
    output logic           o_busy,
    output logic           o_req_valid,
    output t_req           o_req
);

    t_req              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              acc, pop;
    t_req              cls;

    assign o_busy      = (r_cnt == QCNT_W'(QDEPTH));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rd];
    assign acc         = i_start & ~o_busy;
    assign pop         = i_pop & o_req_valid;

    // Split sign and magnitude up front; flag unused modes.
    always_comb begin
        cls.mode = i_mode;
        cls.ok   = (i_mode <= MODE_F2T);
        cls.neg  = i_value_in[X_W-1];
        cls.mag  = i_value_in[X_W-1] ? (X_W'(0) - i_value_in) : i_value_in;
        n_cnt    = r_cnt + QCNT_W'(acc) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (acc) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_q[r_wr] <= cls;
    end

endmodule

FILE: sv/tsr_back.sv
module tsr_back import tsr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_req_valid,
    input  t_req           i_req,
    output logic           o_pop,
    output logic           o_valid,
    output logic [X_W-1:0] o_value_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_SEL  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DIV  = 5'b10000
    } t_state;

    t_state            r_state;
    t_req              r_req;
    logic [MD_W-1:0]   r_den_s, r_m, r_d;
    logic [2:0]        r_k;
    logic [1:0]        r_pk;
    logic [PP_W-1:0]   r_pp;
    logic [PROD_W-1:0] r_acc;
    logic [MD_W-1:0]   r_rem;
    logic [DC_W-1:0]   r_dc;
    logic              r_valid;
    logic [X_W-1:0]    r_out;

    logic [XH_W-1:0]   xa;
    logic [M_LO_W-1:0] ma;
    logic [PROD_W-1:0] pp_sh, acc_sum;
    logic [MD_W:0]     rem_sh, rem_sub;
    logic              ge;
    logic [PROD_W-1:0] acc_div;
    logic [X_W-1:0]    q;

    assign o_pop       = (r_state == S_IDLE) & i_req_valid;
    assign o_valid     = r_valid;
    assign o_value_out = r_out;

    always_comb begin
        xa      = r_k[0] ? r_req.mag[X_W-1:XH_W] : r_req.mag[XH_W-1:0];
        ma      = r_k[1] ? M_LO_W'(r_m[MD_W-1:M_LO_W]) : r_m[M_LO_W-1:0];
        pp_sh   = PROD_W'(r_pp) << ((r_pk[0] ? XH_W : 0) + (r_pk[1] ? M_LO_W : 0));
        acc_sum = r_acc + pp_sh;
        rem_sh  = {r_rem, r_acc[PROD_W-1]};
        ge      = (rem_sh >= {1'b0, r_d});
        rem_sub = ge ? (rem_sh - {1'b0, r_d}) : rem_sh;
        acc_div = {r_acc[PROD_W-2:0], ge};
        q       = acc_div[X_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_pop) r_state <= S_PREP;
                S_PREP: r_state <= S_SEL;
                S_SEL:  r_state <= S_MUL;
                S_MUL:  if (r_k == 3'd4) r_state <= S_DIV;
                S_DIV: begin
                    if (r_dc == DC_W'(PROD_W - 1)) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (o_pop) r_req <= i_req;
            S_PREP: r_den_s <= MD_W'(i_cfg.frame_den) * MD_W'(TIME_SCALE);
            S_SEL: begin
                // Pick multiplier and divisor for the requested conversion.
                case (r_req.mode)
                    MODE_S2T: begin
                        r_m <= MD_W'(TIME_SCALE);
                        r_d <= MD_W'(i_cfg.sample_rate);
                    end
                    MODE_T2S: begin
                        r_m <= MD_W'(i_cfg.sample_rate);
                        r_d <= MD_W'(TIME_SCALE);
                    end
                    MODE_RESCALE: begin
                        r_m <= MD_W'(i_cfg.scale_to);
                        r_d <= MD_W'(i_cfg.scale_from);
                    end
                    MODE_T2F: begin
                        r_m <= MD_W'(i_cfg.frame_num);
                        r_d <= r_den_s;
                    end
                    MODE_F2T: begin
                        r_m <= r_den_s;
                        r_d <= MD_W'(i_cfg.frame_num);
                    end
                    default: begin
                        r_m <= MD_W'(1);
                        r_d <= MD_W'(1);
                    end
                endcase
                r_acc <= '0;
                r_k   <= '0;
            end
            S_MUL: begin
                if (r_k != 3'd4) r_pp <= PP_W'(xa * ma);
                if (r_k != 3'd0) r_acc <= acc_sum;
                r_pk  <= r_k[1:0];
                r_k   <= r_k + 3'd1;
                r_rem <= '0;
                r_dc  <= '0;
            end
            S_DIV: begin
                r_acc <= acc_div;
                r_rem <= rem_sub[MD_W-1:0];
                r_dc  <= r_dc + 1'b1;
                if (r_dc == DC_W'(PROD_W - 1)) begin
                    r_out <= !r_req.ok ? '0 : (r_req.neg ? (X_W'(0) - q) : q);
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/timestamp_rate_rescaler_core.sv
// Timestamp rate rescaler. Raise start with a mode and a signed 64-bit value
// while busy is low and the request is taken at that edge. Each request yields
// exactly one result on o_value_out, shown for one cycle with o_valid high;
// the receiver cannot stall, so capture it in that cycle. Every conversion is
// trunc(x * m / d) wrapped to 64 bits, with m and d picked by mode from the
// rate registers and TIME_SCALE; unused modes (5 to 7) return zero. With the
// back end idle, a request leaves the queue, then passes a setup step for the
// frame denominator scaling, a select step, the multiply (four partial
// products of 32-bit halves of the value, then a final accumulate) and a
// bit-serial divide over the full product width, one quotient bit at a time.
// That divider sets the rate while requests are waiting. A two-entry
// request queue takes new requests while the divider works, so busy rises
// only when two requests are waiting.
// Rate registers sit on the APB port at byte address 4*i; a written zero
// reads back as 1. Write them only while no conversion is in flight.
module timestamp_rate_rescaler_core import tsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_mode,
    input  logic signed [63:0] i_value_in,
    output logic              o_valid,
    output logic signed [63:0] o_value_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg              r_cfg;
    logic              wr_en;
    logic [RATE_W-1:0] wr_val;
    logic [2:0]        idx;
    logic              pop, req_valid;
    t_req              req;
    logic [X_W-1:0]    res;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    // Clamp a written zero rate to 1.
    assign wr_val = (pwdata[RATE_W-1:0] == '0) ? RATE_W'(1) : pwdata[RATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_rate <= RATE_W'(48000);
            r_cfg.scale_from  <= RATE_W'(1000000);
            r_cfg.scale_to    <= RATE_W'(1000000);
            r_cfg.frame_num   <= RATE_W'(30);
            r_cfg.frame_den   <= RATE_W'(1);
        end else if (wr_en) begin
            case (idx)
                REG_SAMPLE_RATE: r_cfg.sample_rate <= wr_val;
                REG_SCALE_FROM:  r_cfg.scale_from  <= wr_val;
                REG_SCALE_TO:    r_cfg.scale_to    <= wr_val;
                REG_FRAME_NUM:   r_cfg.frame_num   <= wr_val;
                REG_FRAME_DEN:   r_cfg.frame_den   <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SAMPLE_RATE: prdata = 32'(r_cfg.sample_rate);
            REG_SCALE_FROM:  prdata = 32'(r_cfg.scale_from);
            REG_SCALE_TO:    prdata = 32'(r_cfg.scale_to);
            REG_FRAME_NUM:   prdata = 32'(r_cfg.frame_num);
            REG_FRAME_DEN:   prdata = 32'(r_cfg.frame_den);
            default:         prdata = '0;
        endcase
    end

    // Front: take requests, split sign/magnitude, queue them.
    tsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_value_in  (i_value_in),
        .i_pop       (pop),
        .o_busy      (busy),
        .o_req_valid (req_valid),
        .o_req       (req)
    );

    // Back: multiply, divide, restore sign, drive the result strobe.
    tsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_value_out (res)
    );

    assign o_value_out = res;

endmodule

FILE: sv/tsr_checker.sv
module tsr_checker import tsr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic              pready
);

    // Reset leaves no result pending and the queue open.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !busy)
        else $error("result or busy after reset");

    // Each result waits on the bit-serial divider; results never come back to back.
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results on consecutive cycles");

    // No result comes out just as reset is released.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result right after reset");

    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind timestamp_rate_rescaler_core tsr_checker u_tsr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .pready  (pready)
);

FILE: tb/sv/tsr_checker.sv
module tsr_tb_checker import tsr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [2:0]         i_mode,
    input  logic signed [63:0] i_value_in,
    input  logic               i_valid,
    input  logic signed [63:0] i_value_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [RATE_W-1:0] sample_rate, scale_from, scale_to, frame_num, frame_den;
    logic [63:0]       expected_values[$];

    // (x rem d) * m / d + (x quo d) * m, both divisions truncating toward zero
    function automatic logic [63:0] split_muldiv(longint x, longint m, longint d);
        longint q;
        longint r;
        q = x / d;
        r = x % d;
        return ((r * m) / d) + q * m;
    endfunction

    // sign(x) * low64(|x| * m / d) over the exact 128-bit product
    function automatic logic [63:0] wide_muldiv(logic [63:0] x, logic [63:0] m,
                                                logic [63:0] d);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] quo;
        neg  = x[63];
        mag  = neg ? -x : x;
        prod = {64'd0, mag} * {64'd0, m};
        quo  = prod / {64'd0, d};
        return neg ? -quo[63:0] : quo[63:0];
    endfunction

    function automatic logic [63:0] converted_value(logic [2:0] mode, logic [63:0] x);
        logic [63:0] den_scaled;
        den_scaled = 64'(frame_den) * 64'(TIME_SCALE);
        case (mode)
            MODE_S2T:     return split_muldiv(x, TIME_SCALE, sample_rate);
            MODE_T2S:     return split_muldiv(x, sample_rate, TIME_SCALE);
            MODE_RESCALE: begin
                if (scale_from == scale_to) return x;
                return split_muldiv(x, scale_to, scale_from);
            end
            MODE_T2F:     return wide_muldiv(x, 64'(frame_num), den_scaled);
            MODE_F2T:     return wide_muldiv(x, den_scaled, 64'(frame_num));
            default:      return 64'd0;
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] clamped_rate(logic [31:0] v);
        return (v[RATE_W-1:0] == '0) ? RATE_W'(1) : v[RATE_W-1:0];
    endfunction

    assign o_pending = expected_values.size();

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            sample_rate  <= RATE_W'(48000);
            scale_from   <= RATE_W'(1000000);
            scale_to     <= RATE_W'(1000000);
            frame_num    <= RATE_W'(30);
            frame_den    <= RATE_W'(1);
            o_fail_count <= 0;
            expected_values.delete();
        end else begin
            // compare before queuing so a stray result never meets a fresh request
            if (i_valid) begin
                if (expected_values.size() == 0) begin
                    $error("value_out: no request pending, got %0d", i_value_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_values.pop_front();
                    if (want !== i_value_out) begin
                        $error("value_out mismatch: expected %0d, got %0d",
                               $signed(want), i_value_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_values.push_back(converted_value(i_mode, i_value_in));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_SAMPLE_RATE: sample_rate <= clamped_rate(i_pwdata);
                    REG_SCALE_FROM:  scale_from  <= clamped_rate(i_pwdata);
                    REG_SCALE_TO:    scale_to    <= clamped_rate(i_pwdata);
                    REG_FRAME_NUM:   frame_num   <= clamped_rate(i_pwdata);
                    REG_FRAME_DEN:   frame_den   <= clamped_rate(i_pwdata);
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: tb/sv/tb.sv
module tb;
    import tsr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 150;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         mode;
    logic signed [63:0] value_in;
    logic               valid;
    logic signed [63:0] value_out;
    logic               psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata, prdata;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    int                 sender_idle_pct;

    timestamp_rate_rescaler_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (mode),
        .i_value_in  (value_in),
        .o_valid     (valid),
        .o_value_out (value_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tsr_tb_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_mode       (mode),
        .i_value_in   (value_in),
        .i_valid      (valid),
        .i_value_out  (value_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a hung run; the slowest correct run stays far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Hold start high across back-to-back requests; drop it only for a gap.
    task automatic send_request(logic [2:0] m, logic [63:0] v);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start    <= 1'b1;
        mode     <= m;
        value_in <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain every outstanding request so registers change only while idle.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_value();
        case ($urandom_range(5))
            0:       return {$urandom, $urandom};
            1:       return 64'($signed($urandom_range(2000)) - 1000);
            2:       return {{32{1'($urandom_range(1))}}, $urandom};
            3:       return $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF
                                              : 64'h8000_0000_0000_0000;
            default: return 64'($signed({$urandom, $urandom}) >>> $urandom_range(63));
        endcase
    endfunction

    function automatic logic [31:0] random_rate();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(100);
            2:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom_range(2000000);
        endcase
    endfunction

    initial begin
        logic [2:0]  m;
        logic [63:0] edge_vals[6];
        logic [31:0] shared;
        edge_vals = '{64'd0, 64'd1, -64'sd1, 64'h7FFF_FFFF_FFFF_FFFF,
                      64'h8000_0000_0000_0000, 64'd123456789};
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        mode        <= MODE_S2T;
        value_in    <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        cycle_count <= 0;
        sender_idle_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset rates, every mode including unused ones, field extremes.
        for (int i = 0; i < 8; i++) send_request(3'(i), edge_vals[i % 6]);
        foreach (edge_vals[i]) send_request(MODE_T2F, edge_vals[i]);
        foreach (edge_vals[i]) send_request(MODE_F2T, edge_vals[i]);
        send_request(MODE_RESCALE, 64'h8000_0000_0000_0000);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            // Rate settings: top extremes, zero writes clamped to one, mixed extremes, equal scale rates, then random.
            case (phase)
                0: for (int r = 0; r < 8; r++) write_rate(3'(r), 32'hFFFF_FFFF);
                1: for (int r = 0; r < 8; r++) write_rate(3'(r), 32'h0);
                2: begin
                    write_rate(REG_SAMPLE_RATE, 32'h7FFF_FFFF);
                    write_rate(REG_SCALE_FROM,  32'd1);
                    write_rate(REG_SCALE_TO,    32'h7FFF_FFFF);
                    write_rate(REG_FRAME_NUM,   32'd1);
                    write_rate(REG_FRAME_DEN,   32'h7FFF_FFFF);
                end
                3: begin
                    shared = random_rate();
                    write_rate(REG_SCALE_FROM, shared);
                    write_rate(REG_SCALE_TO,   shared | 32'h8000_0000);
                    write_rate(REG_SAMPLE_RATE, random_rate());
                    write_rate(REG_FRAME_NUM,   random_rate());
                    write_rate(REG_FRAME_DEN,   random_rate());
                end
                default: for (int r = 0; r < 8; r++) write_rate(3'(r), random_rate());
            endcase
            sender_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 50 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                m = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(4));
                send_request(m, random_value());
            end
            wait_drained();
        end

        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
